@@ src/sqlw_pkg.sv @@
// Shared types, codes and helpers for the SQL window function stream.
`default_nettype none
package sqlw_pkg;

    localparam int LAG_DEPTH_DEF = 16;

    localparam int KEY_W  = 64;
    localparam int ARG_W  = 32;
    localparam int CNT_W  = 32;
    localparam int RES_W  = 64;
    localparam int FSEL_W = 4;
    localparam int LOFF_W = 5;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 5;

    localparam logic [CIDX_W-1:0] CFG_FSEL    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LAG_OFF = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ARG_PRS = 2'd2;

    typedef enum logic [FSEL_W-1:0] {
        F_ROWNUM = 4'd0,
        F_RANK   = 4'd1,
        F_DENSE  = 4'd2,
        F_LAG    = 4'd3,
        F_COUNT  = 4'd4,
        F_SUM    = 4'd5,
        F_AVG    = 4'd6,
        F_MIN    = 4'd7,
        F_MAX    = 4'd8
    } t_func;

    typedef struct packed {
        logic capture;
        logic calc;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        sat_inc = (x == {CNT_W{1'b1}}) ? x : x + 1'b1;
    endfunction

endpackage
`default_nettype wire

@@ src/sql_window_function_stream.sv @@
// Top level of the SQL window function stream: controller plus datapath.
//
//  channel   direction  handshake           payload
//  row in    input      i_valid / o_ready   first_in_partition, order_key(+valid), arg(+valid)
//  result    output     o_valid / i_ready   result_value, result_valid
//  config    input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// Each row passes through capture, compute and deliver; with the average
// selected and a nonzero count, the 64-step serial divider (one quotient bit
// a cycle) runs between compute and deliver. The output register frees the
// input side, so the next row is taken while a result still waits downstream.
// Reset is synchronous, active low, and brings back the register defaults
// with empty running state; the lag memory is not cleared. A stalled consumer
// holds the row in the deliver step until the output register drains.
`default_nettype none
module sql_window_function_stream
    import sqlw_pkg::*;
#(
    parameter int LAG_DEPTH = LAG_DEPTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire  [CIDX_W-1:0]        i_cfg_idx,
    input  wire  [CDAT_W-1:0]        i_cfg_data,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire                      i_first_in_partition,
    input  wire  signed [KEY_W-1:0]  i_order_key,
    input  wire                      i_order_key_valid,
    input  wire  signed [ARG_W-1:0]  i_arg_value,
    input  wire                      i_arg_valid,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic signed [RES_W-1:0]  o_result_value,
    output logic                     o_result_valid
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each transaction through its steps.
    sqlw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold config and running state, compute and divide.
    sqlw_dp #(
        .LAG_DEPTH (LAG_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_first    (i_first_in_partition),
        .i_key      (i_order_key),
        .i_key_v    (i_order_key_valid),
        .i_arg      (i_arg_value),
        .i_arg_v    (i_arg_valid),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_value    (o_result_value),
        .o_value_v  (o_result_valid)
    );

endmodule
`default_nettype wire

@@ src/sqlw_ctrl.sv @@
// Sequencer for the window function stream: accept, compute, divide, deliver.
`default_nettype none
module sqlw_ctrl
    import sqlw_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    output logic o_valid,
    input  wire  i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_HOLD} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_HOLD) && slot_free;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_CALC;
            S_CALC: n_state = i_sts.need_div ? S_DIV : S_HOLD;
            S_DIV:  if (i_sts.div_done) n_state = S_HOLD;
            S_HOLD: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("result loaded over an untaken result");
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CALC))
        else $error("accepted transaction not computed next");
    a_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step |-> (!o_cmd.calc && !o_cmd.capture && !o_cmd.load_out))
        else $error("divider step overlaps another command");

endmodule
`default_nettype wire

@@ src/sqlw_dp.sv @@
// Datapath: config, running state, lag memory, serial divider, result registers.
`default_nettype none
module sqlw_dp
    import sqlw_pkg::*;
#(
    parameter int LAG_DEPTH = LAG_DEPTH_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire  [CIDX_W-1:0]         i_cfg_idx,
    input  wire  [CDAT_W-1:0]         i_cfg_data,
    input  wire                       i_first,
    input  wire  signed [KEY_W-1:0]   i_key,
    input  wire                       i_key_v,
    input  wire  signed [ARG_W-1:0]   i_arg,
    input  wire                       i_arg_v,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic signed [RES_W-1:0]   o_value,
    output logic                      o_value_v
);

    localparam int PTR_W = (LAG_DEPTH > 1) ? $clog2(LAG_DEPTH) : 1;
    localparam int AW    = PTR_W + 6;
    localparam int DIVC_W = $clog2(RES_W);

    logic [FSEL_W-1:0] r_fsel;
    logic [LOFF_W-1:0] r_lag_off;
    logic              r_arg_prs;

    logic                     r_first, r_key_v, r_arg_v;
    logic signed [KEY_W-1:0]  r_key;
    logic signed [ARG_W-1:0]  r_arg;

    logic [CNT_W-1:0]         r_row_pos, r_rank, r_dense, r_cnt;
    logic signed [KEY_W-1:0]  r_prev_key;
    logic                     r_prev_key_v;
    logic signed [RES_W-1:0]  r_sum;
    logic signed [ARG_W-1:0]  r_min, r_max;

    logic [ARG_W:0]           r_lag_mem [LAG_DEPTH];
    logic [ARG_W:0]           r_lag_rd;
    logic [PTR_W-1:0]         r_wr_ptr;

    logic signed [RES_W-1:0]  r_res;
    logic                     r_res_v;
    logic signed [RES_W-1:0]  r_out;
    logic                     r_out_v;

    logic [CNT_W-1:0]         r_div_d;
    logic [RES_W-1:0]         r_div_q;
    logic [CNT_W-1:0]         r_div_r;
    logic                     r_div_neg;
    logic [DIVC_W-1:0]        r_div_cnt;

    // lag read address
    logic             off_ok;
    logic [AW-1:0]    addr_w;
    logic [PTR_W-1:0] rd_addr;

    always_comb begin
        off_ok = (r_lag_off != '0) && (32'(r_lag_off) <= 32'(LAG_DEPTH));
        addr_w = AW'(r_wr_ptr) + AW'(LAG_DEPTH) - AW'(r_lag_off);
        if (addr_w >= AW'(LAG_DEPTH)) addr_w = addr_w - AW'(LAG_DEPTH);
        rd_addr = off_ok ? addr_w[PTR_W-1:0] : r_wr_ptr;
    end

    // running state update
    logic [CNT_W-1:0]        pos, b_rank, b_dense, b_cnt, n_rank, n_dense, n_cnt;
    logic signed [RES_W-1:0] b_sum, n_sum;
    logic signed [ARG_W-1:0] n_min, n_max;
    logic                    tie, upd;
    logic signed [RES_W:0]   s65;
    logic signed [RES_W-1:0] res_val;
    logic                    res_v;
    logic                    lag_in;

    always_comb begin
        pos     = r_first ? '0 : r_row_pos;
        b_rank  = r_first ? '0 : r_rank;
        b_dense = r_first ? '0 : r_dense;
        b_cnt   = r_first ? '0 : r_cnt;
        b_sum   = r_first ? '0 : r_sum;
        tie     = (pos != '0) && r_key_v && r_prev_key_v && (r_key == r_prev_key);
        n_rank  = tie ? b_rank : sat_inc(pos);
        n_dense = tie ? b_dense : sat_inc(b_dense);
        upd     = r_arg_prs && r_arg_v;
        s65     = {b_sum[RES_W-1], b_sum} + {{(RES_W-ARG_W+1){r_arg[ARG_W-1]}}, r_arg};
        n_sum   = b_sum;
        n_cnt   = b_cnt;
        n_min   = r_first ? '0 : r_min;
        n_max   = r_first ? '0 : r_max;
        if (upd) begin
            if (s65[RES_W] != s65[RES_W-1]) begin
                n_sum = s65[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
            end else begin
                n_sum = s65[RES_W-1:0];
            end
            n_cnt = sat_inc(b_cnt);
            if (b_cnt == '0) begin
                n_min = r_arg;
                n_max = r_arg;
            end else begin
                if (r_arg < n_min) n_min = r_arg;
                if (r_arg > n_max) n_max = r_arg;
            end
        end
        lag_in = (32'(r_lag_off) <= pos) && off_ok;
        res_val = '0;
        res_v   = 1'b0;
        case (r_fsel)
            F_ROWNUM: begin res_val = RES_W'(sat_inc(pos)); res_v = 1'b1; end
            F_RANK:   begin res_val = RES_W'(n_rank);       res_v = 1'b1; end
            F_DENSE:  begin res_val = RES_W'(n_dense);      res_v = 1'b1; end
            F_LAG: begin
                if (r_lag_off == '0) begin
                    res_v   = r_arg_v;
                    res_val = r_arg_v ? RES_W'(r_arg) : '0;
                end else if (lag_in && r_lag_rd[ARG_W]) begin
                    res_v   = 1'b1;
                    res_val = RES_W'(signed'(r_lag_rd[ARG_W-1:0]));
                end
            end
            F_COUNT:  begin res_val = RES_W'(n_cnt); res_v = 1'b1; end
            F_SUM:    if (n_cnt != '0) begin res_val = n_sum; res_v = 1'b1; end
            F_MIN:    if (n_cnt != '0) begin res_val = RES_W'(n_min); res_v = 1'b1; end
            F_MAX:    if (n_cnt != '0) begin res_val = RES_W'(n_max); res_v = 1'b1; end
            default: begin res_val = '0; res_v = 1'b0; end
        endcase
        o_sts.need_div = (r_fsel == F_AVG) && (n_cnt != '0);
        o_sts.div_done = (r_div_cnt == '0);
    end

    // one quotient bit per step
    logic [CNT_W:0]   div_sh;
    logic             div_ge;
    logic [RES_W-1:0] div_qn;

    always_comb begin
        div_sh = {r_div_r, r_div_q[RES_W-1]};
        div_ge = div_sh >= {1'b0, r_div_d};
        div_qn = {r_div_q[RES_W-2:0], div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel    <= F_ROWNUM;
            r_lag_off <= LOFF_W'(1);
            r_arg_prs <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FSEL:    r_fsel    <= i_cfg_data[FSEL_W-1:0];
                CFG_LAG_OFF: r_lag_off <= i_cfg_data[LOFF_W-1:0];
                CFG_ARG_PRS: r_arg_prs <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos    <= '0;
            r_rank       <= '0;
            r_dense      <= '0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_prev_key   <= '0;
            r_prev_key_v <= 1'b0;
            r_wr_ptr     <= '0;
        end else if (i_cmd.calc) begin
            r_row_pos    <= sat_inc(pos);
            r_rank       <= n_rank;
            r_dense      <= n_dense;
            r_cnt        <= n_cnt;
            r_sum        <= n_sum;
            r_min        <= n_min;
            r_max        <= n_max;
            r_prev_key   <= r_key;
            r_prev_key_v <= r_key_v;
            r_wr_ptr     <= (r_wr_ptr == PTR_W'(LAG_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
    end

    // lag memory: read on capture, write on compute
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_lag_rd <= r_lag_mem[rd_addr];
        if (i_cmd.calc)    r_lag_mem[r_wr_ptr] <= {r_arg_v, r_arg};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_first <= i_first;
            r_key   <= i_key;
            r_key_v <= i_key_v;
            r_arg   <= i_arg;
            r_arg_v <= i_arg_v;
        end
        if (i_cmd.calc) begin
            r_res     <= res_val;
            r_res_v   <= o_sts.need_div ? 1'b1 : res_v;
            r_div_neg <= n_sum[RES_W-1];
            r_div_q   <= n_sum[RES_W-1] ? RES_W'(-n_sum) : RES_W'(n_sum);
            r_div_r   <= '0;
            r_div_d   <= n_cnt;
            r_div_cnt <= DIVC_W'(RES_W - 1);
        end
        if (i_cmd.div_step) begin
            r_div_q   <= div_qn;
            r_div_r   <= div_ge ? CNT_W'(div_sh - {1'b0, r_div_d}) : div_sh[CNT_W-1:0];
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_div_cnt == '0) r_res <= r_div_neg ? RES_W'(-div_qn) : RES_W'(div_qn);
        end
        if (i_cmd.load_out) begin
            r_out   <= r_res;
            r_out_v <= r_res_v;
        end
    end

    assign o_value   = r_out_v ? r_out : '0;
    assign o_value_v = r_out_v;

endmodule
`default_nettype wire

@@ tb/sv/sql_window_function_stream_test.sv @@
// Testbench for sql_window_function_stream: directed rows, then random partitions.
`timescale 1ns / 100ps
`default_nettype none
module sql_window_function_stream_test;
    import sqlw_pkg::*;

    localparam int LAG_DEPTH  = 16;
    localparam int RAND_ROWS  = 1550;
    localparam int SETTLE     = 80;     // longer than the average (divider) path
    localparam int STALL_LIMIT = 3000;  // cycles with no transaction on any channel

    // One row of stimulus together with the settings it runs under.
    // When check_lit is set the expected result is typed in directly.
    typedef struct {
        logic [FSEL_W-1:0]       fsel;
        logic [LOFF_W-1:0]       loff;
        logic                    aprs;
        logic                    first;
        logic signed [KEY_W-1:0] key;
        logic                    key_ok;
        logic signed [ARG_W-1:0] arg;
        logic                    arg_ok;
        logic                    check_lit;
        logic signed [RES_W-1:0] lit_value;
        logic                    lit_valid;
    } t_row;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    valid;
    } t_window_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CIDX_W-1:0]        i_cfg_idx;
    logic [CDAT_W-1:0]        i_cfg_data;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_first_in_partition;
    logic signed [KEY_W-1:0]  i_order_key;
    logic                     i_order_key_valid;
    logic signed [ARG_W-1:0]  i_arg_value;
    logic                     i_arg_valid;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [RES_W-1:0]  o_result_value;
    logic                     o_result_valid;

    // Side-band with the row being offered: a typed-in expectation, if any.
    logic                     row_check_lit;
    t_window_result           row_lit;

    sql_window_function_stream u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_first_in_partition (i_first_in_partition),
        .i_order_key          (i_order_key),
        .i_order_key_valid    (i_order_key_valid),
        .i_arg_value          (i_arg_value),
        .i_arg_valid          (i_arg_valid),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_result_value       (o_result_value),
        .o_result_valid       (o_result_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Window predictor: its own copy of the registers and running state.
    // ------------------------------------------------------------------
    logic [FSEL_W-1:0]        win_fsel;
    logic [LOFF_W-1:0]        win_loff;
    logic                     win_aprs;
    logic [CNT_W-1:0]         win_pos;
    logic [CNT_W-1:0]         win_rank;
    logic [CNT_W-1:0]         win_dense;
    logic signed [KEY_W-1:0]  win_prev_key;
    logic                     win_prev_key_ok;
    logic signed [63:0]       win_sum;
    logic [CNT_W-1:0]         win_count;
    logic signed [ARG_W-1:0]  win_min;
    logic signed [ARG_W-1:0]  win_max;
    logic signed [ARG_W-1:0]  hist_value [LAG_DEPTH];
    logic                     hist_ok    [LAG_DEPTH];

    t_window_result           pending_results [$];
    t_row                     directed_rows [$];
    int                       error_count;
    int                       idle_cycles;

    // Append an expected result behind the ones still outstanding.
    task automatic queue_result(input t_window_result r);
        pending_results = {pending_results, r};
    endtask

    // Append a row to the directed table.
    task automatic queue_row(input t_row r);
        directed_rows = {directed_rows, r};
    endtask

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    // Hold the sum at the signed 64-bit bounds.
    function automatic logic signed [63:0] sum_clamp(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] wide;
        wide = {a[63], a} + {b[63], b};
        if (wide[64] != wide[63])
            return wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return wide[63:0];
    endfunction

    task automatic window_reset();
        win_fsel = F_ROWNUM;
        win_loff = 5'd1;
        win_aprs = 1'b1;
        win_pos = '0;
        win_rank = '0;
        win_dense = '0;
        win_prev_key = '0;
        win_prev_key_ok = 1'b0;
        win_sum = '0;
        win_count = '0;
        win_min = '0;
        win_max = '0;
        for (int i = 0; i < LAG_DEPTH; i++) begin
            hist_value[i] = '0;
            hist_ok[i] = 1'b0;
        end
    endtask

    // Advance the state by one row and return the result for it.
    task automatic window_step(input logic first, input logic signed [KEY_W-1:0] key,
                               input logic key_ok, input logic signed [ARG_W-1:0] arg,
                               input logic arg_ok, output t_window_result res);
        logic [CNT_W-1:0] pos;
        logic             tie;
        res.value = '0;
        res.valid = 1'b0;
        if (first) begin
            win_pos = '0;
            win_rank = '0;
            win_dense = '0;
            win_sum = '0;
            win_count = '0;
            win_min = '0;
            win_max = '0;
        end
        pos = win_pos;
        // A null key never ties, and the first row of a partition never does.
        tie = (pos != 0) && key_ok && win_prev_key_ok && (key == win_prev_key);
        if (!tie) begin
            win_rank = bump(pos);
            win_dense = bump(win_dense);
        end
        if (win_aprs && arg_ok) begin
            if (win_count == 0) begin
                win_min = arg;
                win_max = arg;
            end else begin
                if (arg < win_min) win_min = arg;
                if (arg > win_max) win_max = arg;
            end
            win_sum = sum_clamp(win_sum, 64'(arg));
            win_count = bump(win_count);
        end
        case (win_fsel)
            F_ROWNUM: res = '{64'(bump(pos)), 1'b1};
            F_RANK:   res = '{64'(win_rank), 1'b1};
            F_DENSE:  res = '{64'(win_dense), 1'b1};
            F_LAG: begin
                if (win_loff == 0) begin
                    if (arg_ok) res = '{64'(arg), 1'b1};
                end else if (win_loff <= LAG_DEPTH && win_loff <= pos) begin
                    if (hist_ok[win_loff - 1]) res = '{64'(hist_value[win_loff - 1]), 1'b1};
                end
            end
            F_COUNT: res = '{64'(win_count), 1'b1};
            F_SUM:   if (win_count != 0) res = '{win_sum, 1'b1};
            F_AVG:   if (win_count != 0) res = '{win_sum / $signed({32'd0, win_count}), 1'b1};
            F_MIN:   if (win_count != 0) res = '{64'(win_min), 1'b1};
            F_MAX:   if (win_count != 0) res = '{64'(win_max), 1'b1};
            default: ;  // unused selector: null
        endcase
        for (int i = LAG_DEPTH - 1; i > 0; i--) begin
            hist_value[i] = hist_value[i - 1];
            hist_ok[i] = hist_ok[i - 1];
        end
        hist_value[0] = arg;
        hist_ok[0] = arg_ok;
        win_pos = bump(pos);
        win_prev_key = key;
        win_prev_key_ok = key_ok;
    endtask

    task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                   input logic [RES_W-1:0] want);
        error_count++;
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_window_result res;
        t_window_result want;
        logic           busy;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            busy = 1'b0;
            if (i_cfg_we) begin
                busy = 1'b1;
                case (i_cfg_idx)
                    CFG_FSEL:    win_fsel = i_cfg_data[FSEL_W-1:0];
                    CFG_LAG_OFF: win_loff = i_cfg_data[LOFF_W-1:0];
                    CFG_ARG_PRS: win_aprs = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                busy = 1'b1;
                window_step(i_first_in_partition, i_order_key, i_order_key_valid,
                            i_arg_value, i_arg_valid, res);
                // Typed-in rows must agree with the predictor as well.
                if (row_check_lit && (res.value !== row_lit.value || res.valid !== row_lit.valid))
                    report_mismatch("predictor vs typed row", {res.value}, {row_lit.value});
                queue_result(row_check_lit ? row_lit : res);
            end
            if (o_valid && i_ready) begin
                busy = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_result_value, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result_valid !== want.valid)
                        report_mismatch("result_valid", {63'd0, o_result_valid},
                                        {63'd0, want.valid});
                    if (o_result_value !== want.value)
                        report_mismatch("result_value", o_result_value, want.value);
                end
            end
            idle_cycles <= busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: stall a random number of cycles before each result.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            // Sometimes skip the stall so results can leave back to back.
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ------------------------------------------------------------------
    // Row source and register writes.
    // ------------------------------------------------------------------
    logic [FSEL_W-1:0] cur_fsel;
    logic [LOFF_W-1:0] cur_loff;
    logic              cur_aprs;
    logic              no_gaps;

    // Wait for every result, then let the divider settle before writing.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [FSEL_W-1:0] fsel, input logic [LOFF_W-1:0] loff,
                              input logic aprs);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_FSEL;
        i_cfg_data <= CDAT_W'(fsel);
        @(negedge i_clk);
        i_cfg_idx <= CFG_LAG_OFF;
        i_cfg_data <= CDAT_W'(loff);
        @(negedge i_clk);
        i_cfg_idx <= CFG_ARG_PRS;
        i_cfg_data <= CDAT_W'(aprs);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fsel = fsel;
        cur_loff = loff;
        cur_aprs = aprs;
    endtask

    // Offer one row; valid stays high into the next row when there is no gap.
    task automatic send_row(input t_row r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_in_partition <= r.first;
        i_order_key <= r.key;
        i_order_key_valid <= r.key_ok;
        i_arg_value <= r.arg;
        i_arg_valid <= r.arg_ok;
        row_check_lit <= r.check_lit;
        row_lit <= '{r.lit_value, r.lit_valid};
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic t_row mk(input logic [FSEL_W-1:0] fsel, input logic [LOFF_W-1:0] loff,
                                input logic aprs, input logic first,
                                input logic signed [KEY_W-1:0] key, input logic key_ok,
                                input logic signed [ARG_W-1:0] arg, input logic arg_ok,
                                input logic check_lit = 1'b0,
                                input logic signed [RES_W-1:0] lit_value = '0,
                                input logic lit_valid = 1'b0);
        t_row r;
        r = '{fsel, loff, aprs, first, key, key_ok, arg, arg_ok, check_lit, lit_value,
              lit_valid};
        return r;
    endfunction

    localparam logic signed [KEY_W-1:0] KMIN = {1'b1, 63'd0};
    localparam logic signed [KEY_W-1:0] KMAX = {1'b0, {63{1'b1}}};
    localparam logic signed [ARG_W-1:0] AMIN = {1'b1, 31'd0};
    localparam logic signed [ARG_W-1:0] AMAX = {1'b0, {31{1'b1}}};

    function automatic logic signed [KEY_W-1:0] rand_key(input int pool);
        case ($urandom_range(0, 5))
            0: return KMIN;
            1: return KMAX;
            2: return {$urandom, $urandom};
            default: return KEY_W'($urandom_range(0, pool));  // small pool gives ties
        endcase
    endfunction

    function automatic logic signed [ARG_W-1:0] rand_arg();
        case ($urandom_range(0, 7))
            0: return AMIN;
            1: return AMAX;
            2: return ARG_W'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_row r;
        int   sent;
        int   part_left;
        int   phase_rows;
        int   pool;
        logic [FSEL_W-1:0] fsel;
        logic [LOFF_W-1:0] loff;

        error_count = 0;
        no_gaps = 1'b0;
        window_reset();
        cur_fsel = F_ROWNUM;
        cur_loff = 5'd1;
        cur_aprs = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FSEL;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_first_in_partition = 1'b0;
        i_order_key = '0;
        i_order_key_valid = 1'b0;
        i_arg_value = '0;
        i_arg_valid = 1'b0;
        row_check_lit = 1'b0;
        row_lit = '{'0, 1'b0};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: stream start without a partition mark, ties and null keys,
        // lag edges, absent and null arguments, large argument sums and an unused selector.
        queue_row(mk(F_ROWNUM, 5'd1, 1'b1, 1'b0, 64'd0, 1'b1, 32'd0, 1'b1,
                     1'b1, 64'd1, 1'b1));
        queue_row(mk(F_ROWNUM, 5'd1, 1'b1, 1'b0, 64'd0, 1'b1, 32'd0, 1'b1,
                     1'b1, 64'd2, 1'b1));
        queue_row(mk(F_RANK, 5'd1, 1'b1, 1'b1, 64'd5, 1'b1, 32'd1, 1'b1,
                     1'b1, 64'd1, 1'b1));
        queue_row(mk(F_RANK, 5'd1, 1'b1, 1'b0, 64'd5, 1'b1, 32'd1, 1'b1));
        queue_row(mk(F_RANK, 5'd1, 1'b1, 1'b0, KMAX, 1'b0, 32'd1, 1'b1));
        queue_row(mk(F_RANK, 5'd1, 1'b1, 1'b0, KMAX, 1'b0, 32'd1, 1'b1));
        queue_row(mk(F_DENSE, 5'd1, 1'b1, 1'b1, KMIN, 1'b1, 32'd0, 1'b0,
                     1'b1, 64'd1, 1'b1));
        queue_row(mk(F_DENSE, 5'd1, 1'b1, 1'b0, KMIN, 1'b1, 32'd0, 1'b0));
        queue_row(mk(F_DENSE, 5'd1, 1'b1, 1'b0, KMAX, 1'b1, 32'd0, 1'b0));
        queue_row(mk(F_LAG, 5'd0, 1'b1, 1'b1, 64'd1, 1'b1, AMIN, 1'b1,
                     1'b1, 64'(AMIN), 1'b1));
        queue_row(mk(F_LAG, 5'd2, 1'b1, 1'b1, 64'd1, 1'b1, AMAX, 1'b1,
                     1'b1, 64'd0, 1'b0));
        queue_row(mk(F_LAG, 5'd2, 1'b1, 1'b0, 64'd2, 1'b1, 32'd7, 1'b0));
        queue_row(mk(F_LAG, 5'd2, 1'b1, 1'b0, 64'd3, 1'b1, 32'd9, 1'b1,
                     1'b1, 64'(AMAX), 1'b1));
        queue_row(mk(F_LAG, 5'd31, 1'b1, 1'b0, 64'd4, 1'b1, 32'd9, 1'b1,
                     1'b1, 64'd0, 1'b0));
        queue_row(mk(F_COUNT, 5'd16, 1'b0, 1'b1, 64'd0, 1'b1, 32'd3, 1'b1,
                     1'b1, 64'd0, 1'b1));
        queue_row(mk(F_SUM, 5'd16, 1'b1, 1'b1, 64'd0, 1'b1, 32'd3, 1'b0,
                     1'b1, 64'd0, 1'b0));
        queue_row(mk(F_SUM, 5'd16, 1'b1, 1'b0, 64'd0, 1'b1, AMAX, 1'b1,
                     1'b1, 64'(AMAX), 1'b1));
        queue_row(mk(F_SUM, 5'd16, 1'b1, 1'b0, 64'd0, 1'b1, AMAX, 1'b1));
        queue_row(mk(F_AVG, 5'd16, 1'b1, 1'b1, 64'd0, 1'b1, -32'sd3, 1'b1));
        queue_row(mk(F_AVG, 5'd16, 1'b1, 1'b0, 64'd0, 1'b1, 32'd0, 1'b1));
        queue_row(mk(F_MIN, 5'd16, 1'b1, 1'b1, 64'd0, 1'b1, AMAX, 1'b1));
        queue_row(mk(F_MIN, 5'd16, 1'b1, 1'b0, 64'd0, 1'b1, AMIN, 1'b1,
                     1'b1, 64'(AMIN), 1'b1));
        queue_row(mk(F_MAX, 5'd16, 1'b1, 1'b0, 64'd0, 1'b1, AMAX, 1'b1,
                     1'b1, 64'(AMAX), 1'b1));
        queue_row(mk(4'd15, 5'd16, 1'b1, 1'b0, 64'd0, 1'b1, 32'd1, 1'b1,
                     1'b1, 64'd0, 1'b0));

        @(negedge i_clk);
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.fsel != cur_fsel || r.loff != cur_loff || r.aprs != cur_aprs)
                write_regs(r.fsel, r.loff, r.aprs);
            send_row(r);
        end

        // Random phases: new settings, then partitions of random length.
        sent = 0;
        while (sent < RAND_ROWS) begin
            fsel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            case ($urandom_range(0, 5))
                0: loff = 5'd0;
                1: loff = 5'd16;
                2: loff = 5'd31;
                3: loff = 5'd1;
                default: loff = 5'($urandom_range(0, 31));
            endcase
            write_regs(fsel, loff, ($urandom_range(0, 4) != 0));
            no_gaps = ($urandom_range(0, 3) == 0);
            pool = $urandom_range(1, 6);
            phase_rows = $urandom_range(60, 140);
            part_left = 0;
            repeat (phase_rows) begin
                r.first = (part_left == 0) || ($urandom_range(0, 40) == 0);
                if (r.first) part_left = $urandom_range(1, 24);
                part_left--;
                r.key = rand_key(pool);
                r.key_ok = ($urandom_range(0, 7) != 0);
                r.arg = rand_arg();
                r.arg_ok = ($urandom_range(0, 5) != 0);
                r.check_lit = 1'b0;
                r.lit_value = '0;
                r.lit_valid = 1'b0;
                send_row(r);
                sent++;
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
src/sqlw_pkg.sv
src/sqlw_ctrl.sv
src/sqlw_dp.sv
src/sql_window_function_stream.sv
tb/sv/sql_window_function_stream_test.sv
